FILE: sv/crs_pkg.sv
// ============================================================================
// crs_pkg
// Shared constants, codes and helpers for the cipher rotor stepper.
// ============================================================================
package crs_pkg;

    // Sizes
    localparam int MAX_LETTERS = 64;
    localparam int LW          = 7;   // letter index width (0..64)
    localparam int AW          = 6;   // wiring memory address width
    localparam int OPW         = 3;
    localparam int IN_TDATA_W  = 24;  // 17 field bits padded to bytes
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // Operation codes
    localparam logic [OPW-1:0] OP_MAP_RL = 3'd0;
    localparam logic [OPW-1:0] OP_MAP_LR = 3'd1;
    localparam logic [OPW-1:0] OP_ROTATE = 3'd2;
    localparam logic [OPW-1:0] OP_LOAD   = 3'd3;
    localparam logic [OPW-1:0] OP_SETPOS = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTCH = 2'd2;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    // Reset values
    localparam logic [LW-1:0] SIZE_RST = 7'd26;
    localparam logic [LW-1:0] RING_RST = 7'd1;
    localparam logic [LW-1:0] POS_RST  = 7'd1;

    typedef logic [LW-1:0] t_letter;

    // Clamp a written alphabet size into 2..MAX_LETTERS
    function automatic t_letter clamp_size(input t_letter v);
        t_letter r;
        r = v;
        if (v < 7'd2) r = 7'd2;
        if (v > LW'(MAX_LETTERS)) r = LW'(MAX_LETTERS);
        return r;
    endfunction

    // 1..n check
    function automatic logic in_range(input t_letter v, input t_letter n);
        return (v != '0) && (v <= n);
    endfunction

    // Convert a 1-based letter (1..64) to a memory address
    function automatic logic [AW-1:0] to_addr(input t_letter v);
        t_letter d;
        d = v - 7'd1;
        return d[AW-1:0];
    endfunction

endpackage

FILE: sv/cipher_rotor_stepper.sv
// ============================================================================
// cipher_rotor_stepper
// One substitution rotor: wiring and inverse wiring held in two synchronous
// memories, position and ring offset applied on the way in.
// ============================================================================
//
//  channel  | dir | signals                          | contents
//  ---------+-----+----------------------------------+-------------------------
//  s (item) | in  | i_s_tvalid/o_s_tready/i_s_tdata  | operation, pin, wire_value
//  m (res)  | out | o_m_tvalid/i_m_tready/o_m_tdata  | pin_out, found, position,
//           |     |                                  | at_notch
//  cfg      | in  | i_cfg_valid/o_cfg_ready/...      | register index and data
//
//  Map, rotate, set and undefined codes pass from the execute state to a
//  registered result; load adds a load state (wiring read, then inverse
//  read of the old value, then write back). The wiring memories have
//  registered reads. A new item is taken once the previous result is
//  registered. A stalled output holds the sequencer in its last state.
//  Reset restores position, size, ring and notch, clears loaded bits; memory
//  contents stay. Register writes are taken only while the sequencer idles.
// ============================================================================
module cipher_rotor_stepper (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [2:0] operation, [9:3] pin, [16:10] wire_value, [23:17] zero
    input  logic [crs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // results
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [6:0] pin_out, [7] found, [14:8] position, [15] at_notch
    output logic [crs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [crs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [crs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int N = crs_pkg::MAX_LETTERS;

    // Configuration and rotor state
    crs_pkg::t_letter r_size, r_ring, r_pos;
    logic [N-1:0]     r_notch;
    logic [N-1:0]     r_fwd_ld, r_inv_ld;

    // Latched item
    logic [1:0]                 r_state;
    logic [crs_pkg::OPW-1:0]    r_op;
    crs_pkg::t_letter           r_pin, r_wv, r_s;
    logic                       r_pin_ok, r_wv_ok, r_chk;

    // Wiring memories
    crs_pkg::t_letter mem_fwd [N];
    crs_pkg::t_letter mem_inv [N];
    crs_pkg::t_letter r_fwd_q, r_inv_q;

    // Output register
    logic                            r_out_valid;
    logic [crs_pkg::OUT_TDATA_W-1:0] r_out_data;

    // Item fields
    logic [crs_pkg::OPW-1:0] in_op;
    crs_pkg::t_letter        in_pin, in_wv;
    assign in_op  = i_s_tdata[2:0];
    assign in_pin = i_s_tdata[9:3];
    assign in_wv  = i_s_tdata[16:10];

    logic accept_in, out_free;
    assign o_s_tready  = (r_state == crs_pkg::ST_IDLE);
    assign accept_in   = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_cfg_ready = (r_state == crs_pkg::ST_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Shifted pin: pin + ring offset + position offset, folded twice
    crs_pkg::t_letter ring_eff, s_pin;
    logic [7:0]       sum0, sum1, sum2;
    always_comb begin
        ring_eff = (r_ring == '0 || r_ring > r_size) ? 7'd1 : r_ring;
        sum0 = {1'b0, in_pin} + {1'b0, ring_eff - 7'd1} + {1'b0, r_pos - 7'd1};
        sum1 = (sum0 > {1'b0, r_size}) ? sum0 - {1'b0, r_size} : sum0;
        sum2 = (sum1 > {1'b0, r_size}) ? sum1 - {1'b0, r_size} : sum1;
        s_pin = sum2[6:0];
    end

    // Memory read ports
    logic                fwd_rd_en, inv_rd_en, go_load;
    logic [crs_pkg::AW-1:0] fwd_rd_addr, inv_rd_addr, old_addr, pin_addr;
    assign old_addr = crs_pkg::to_addr(r_fwd_q);
    assign pin_addr = crs_pkg::to_addr(r_pin);
    assign go_load  = (r_state == crs_pkg::ST_EXEC) && (r_op == crs_pkg::OP_LOAD)
                      && r_pin_ok && r_wv_ok;
    always_comb begin
        fwd_rd_en   = accept_in;
        fwd_rd_addr = (in_op == crs_pkg::OP_MAP_RL) ? crs_pkg::to_addr(s_pin)
                                                    : crs_pkg::to_addr(in_pin);
        inv_rd_en   = accept_in || go_load;
        inv_rd_addr = accept_in ? crs_pkg::to_addr(s_pin) : old_addr;
    end

    // Result of the finishing state
    logic             finish, do_write, clear_old, res_found;
    crs_pkg::t_letter res_pout, n_pos, map_v;
    logic             map_ld;
    always_comb begin
        finish   = 1'b0;
        do_write = 1'b0;
        res_found = 1'b0;
        res_pout  = '0;
        n_pos     = r_pos;
        map_v     = (r_op == crs_pkg::OP_MAP_RL) ? r_fwd_q : r_inv_q;
        map_ld    = (r_op == crs_pkg::OP_MAP_RL) ? r_fwd_ld[crs_pkg::to_addr(r_s)]
                                                 : r_inv_ld[crs_pkg::to_addr(r_s)];
        clear_old = r_chk && r_inv_ld[old_addr] && (r_inv_q == r_pin);
        if (r_state == crs_pkg::ST_EXEC && !go_load) begin
            finish = out_free;
            unique case (r_op)
                crs_pkg::OP_MAP_RL, crs_pkg::OP_MAP_LR: begin
                    if (r_pin_ok && map_ld && crs_pkg::in_range(map_v, r_size)) begin
                        res_found = 1'b1;
                        res_pout  = map_v;
                    end
                end
                crs_pkg::OP_ROTATE: begin
                    res_found = 1'b1;
                    n_pos = (r_pos + 7'd1 > r_size) ? 7'd1 : r_pos + 7'd1;
                end
                crs_pkg::OP_SETPOS: begin
                    if (r_pin_ok) begin
                        res_found = 1'b1;
                        n_pos = r_pin;
                    end
                end
                default: begin
                    res_found = 1'b0;
                end
            endcase
        end else if (r_state == crs_pkg::ST_LOAD) begin
            finish    = out_free;
            do_write  = out_free;
            res_found = 1'b1;
        end
    end

    logic at_notch;
    assign at_notch = r_notch[crs_pkg::to_addr(n_pos)];

    // Wiring memories: registered reads, write back at end of a load
    always_ff @(posedge i_clk) begin
        if (fwd_rd_en) r_fwd_q <= mem_fwd[fwd_rd_addr];
        if (inv_rd_en) r_inv_q <= mem_inv[inv_rd_addr];
        if (do_write) begin
            mem_fwd[pin_addr]                  <= r_wv;
            mem_inv[crs_pkg::to_addr(r_wv)]    <= r_pin;
        end
    end

    // Item latch (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_op     <= in_op;
            r_pin    <= in_pin;
            r_wv     <= in_wv;
            r_s      <= s_pin;
            r_pin_ok <= crs_pkg::in_range(in_pin, r_size);
            r_wv_ok  <= crs_pkg::in_range(in_wv, r_size);
        end
        if (go_load) r_chk <= r_fwd_ld[pin_addr];
        if (finish) r_out_data <= {at_notch, n_pos, res_found, res_pout};
    end

    // Sequencer, output valid, loaded bits, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_fwd_ld    <= '0;
            r_inv_ld    <= '0;
            r_pos       <= crs_pkg::POS_RST;
            r_size      <= crs_pkg::SIZE_RST;
            r_ring      <= crs_pkg::RING_RST;
            r_notch     <= '0;
        end else begin
            // output register
            if (finish)          r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;

            // state
            unique case (r_state)
                crs_pkg::ST_IDLE: if (accept_in) r_state <= crs_pkg::ST_EXEC;
                crs_pkg::ST_EXEC: begin
                    if (go_load)     r_state <= crs_pkg::ST_LOAD;
                    else if (finish) r_state <= crs_pkg::ST_IDLE;
                end
                crs_pkg::ST_LOAD: if (finish) r_state <= crs_pkg::ST_IDLE;
                default: r_state <= crs_pkg::ST_IDLE;
            endcase

            // loaded bits: clear stale inverse first, then set the new pair
            if (do_write) begin
                r_fwd_ld[pin_addr] <= 1'b1;
                if (clear_old && old_addr != crs_pkg::to_addr(r_wv))
                    r_inv_ld[old_addr] <= 1'b0;
                r_inv_ld[crs_pkg::to_addr(r_wv)] <= 1'b1;
            end

            // position and configuration registers
            if (finish) begin
                r_pos <= n_pos;
            end else if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    crs_pkg::CFG_SIZE: begin
                        r_size <= crs_pkg::clamp_size(i_cfg_data[6:0]);
                        if (r_pos > crs_pkg::clamp_size(i_cfg_data[6:0]))
                            r_pos <= 7'd1;
                    end
                    crs_pkg::CFG_RING:  r_ring  <= i_cfg_data[6:0];
                    crs_pkg::CFG_NOTCH: r_notch <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule
